[design/drle_pkg.sv]
package drle_pkg;

    localparam int unsigned REG_W   = 31;
    localparam int unsigned LAG_W   = 32;
    localparam int unsigned TIME_W  = 48;
    localparam int unsigned WGT_W   = 17;
    localparam int unsigned DT_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [REG_W-1:0] ONE_Q16  = 31'd65536;
    localparam logic [DT_W-1:0]  HALF_Q16 = 16'd32768;

    localparam logic [REG_W-1:0] RST_MAX_SPEEDUP        = 31'd13107;
    localparam logic [REG_W-1:0] RST_SLOW_DECAY_TIME    = 31'd1966080;
    localparam logic [REG_W-1:0] RST_FAST_DECAY_TIME    = 31'd327680;
    localparam logic [REG_W-1:0] RST_SLOW_WEIGHT        = 31'd13107;
    localparam logic [REG_W-1:0] RST_FAST_WEIGHT        = 31'd65536;
    localparam logic [REG_W-1:0] RST_SINGLE_EVENT_LIMIT = 31'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEEDUP        = 3'd0,
        CFG_SLOW_DECAY_TIME    = 3'd1,
        CFG_FAST_DECAY_TIME    = 3'd2,
        CFG_SLOW_WEIGHT        = 3'd3,
        CFG_FAST_WEIGHT        = 3'd4,
        CFG_SINGLE_EVENT_LIMIT = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_REPORT = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                     opcode;
        logic signed [LAG_W-1:0]  lag_amount;
        logic [REG_W-1:0]         report_weight;
        logic [REG_W-1:0]         delta_time;
        logic [TIME_W-1:0]        now_time;
    } t_in_req;

    typedef struct packed {
        logic signed [LAG_W-1:0]  smooth_lag;
        logic signed [LAG_W-1:0]  fast_lag;
        logic signed [LAG_W-1:0]  slow_lag;
    } t_out_req;

endpackage

[design/dual_rate_lag_estimator.sv]
// Report request: steps through S_R_WS, S_R_WF, S_R_LS, S_R_LF and S_R_FIN, then S_DONE.
// Tick request: S_T_RISE and S_T_LIM, then for each estimate that decays S_T_DMUL, S_T_DSET,
// S_T_DIV and S_T_DEND; both decays share the 33x32 multiplier and one-bit-per-cycle divider.
// One request is in flight at a time; the next is taken once the result is registered, which
// waits while an earlier result is still stalled. Synchronous active-low reset clears all
// estimates, the serious-report time and the control state, and loads the default registers.
module dual_rate_lag_estimator (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [30:0]             i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  drle_pkg::t_in_req       i_in_req,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output drle_pkg::t_out_req      o_out_req
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_R_WS,
        S_R_WF,
        S_R_LS,
        S_R_LF,
        S_R_FIN,
        S_T_RISE,
        S_T_LIM,
        S_T_DMUL,
        S_T_DSET,
        S_T_DIV,
        S_T_DEND,
        S_DONE
    } t_state;

    t_state r_state;

    logic [30:0] r_max_speedup;
    logic [30:0] r_slow_T;
    logic [30:0] r_fast_T;
    logic [30:0] r_slow_weight;
    logic [30:0] r_fast_weight;
    logic [30:0] r_sel_limit;

    logic [47:0]        r_lst;
    logic signed [31:0] r_slow;
    logic signed [31:0] r_fast;
    logic signed [31:0] r_smooth;

    logic signed [31:0] r_lag;
    logic [30:0]        r_weight;
    logic [15:0]        r_dt;
    logic               r_dec_s;
    logic               r_dec_f;
    logic               r_sel;
    logic [16:0]        r_ws;
    logic [16:0]        r_wf;
    logic signed [63:0] r_prod;
    logic [31:0]        r_den;
    logic [31:0]        r_rem;
    logic [31:0]        r_quo;
    logic               r_neg;
    logic [4:0]         r_cnt;

    logic               r_out_valid;
    drle_pkg::t_out_req r_out;

    logic signed [32:0] m_a;
    logic signed [31:0] m_b;
    logic signed [64:0] m_p;

    logic               in_acc;
    logic signed [31:0] lag_clamped;
    logic [48:0]        quiet;
    logic               quiet_pos;
    logic [15:0]        dt_clamped;
    logic signed [31:0] fast_max;
    logic signed [31:0] smooth_rise;
    logic signed [31:0] slow_base;
    logic signed [47:0] lag_term;
    logic [31:0]        dec_den;
    logic [63:0]        dec_mag;
    logic [32:0]        div_try;
    logic [32:0]        div_sub;
    logic [31:0]        dec_val;

    function automatic logic [16:0] clamp_weight(input logic signed [63:0] p);
        logic [45:0] q;
        q = p[61:16];
        if (q > {15'd0, drle_pkg::ONE_Q16}) begin
            return 17'h10000;
        end
        return q[16:0];
    endfunction

    function automatic logic signed [47:0] trunc16(input logic signed [63:0] p);
        logic signed [47:0] q;
        q = p[63:16];
        if (p[63] && (p[15:0] != 16'd0)) begin
            q = q + 48'sd1;
        end
        return q;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        if (!v[48] && (|v[47:31])) begin
            return 32'sh7FFF_FFFF;
        end
        if (v[48] && !(&v[47:31])) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    assign lag_clamped = (i_in_req.lag_amount > $signed({1'b0, r_sel_limit}))
                         ? $signed({1'b0, r_sel_limit}) : i_in_req.lag_amount;
    assign dt_clamped  = (i_in_req.delta_time > {15'd0, drle_pkg::HALF_Q16})
                         ? drle_pkg::HALF_Q16 : i_in_req.delta_time[15:0];
    assign quiet       = {1'b0, i_in_req.now_time} - {1'b0, r_lst};
    assign quiet_pos   = !quiet[48];

    assign fast_max    = (r_fast < r_slow) ? r_slow : r_fast;
    assign smooth_rise = sat32({{17{r_smooth[31]}}, r_smooth} + {18'd0, r_prod[46:16]});
    assign slow_base   = (r_smooth > r_slow) ? r_slow : r_smooth;
    assign lag_term    = trunc16(r_prod);

    assign dec_den = r_sel ? ({1'b0, r_fast_T} + {16'd0, r_dt})
                           : ({1'b0, r_slow_T} + {16'd0, r_dt});
    assign dec_mag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
    assign div_try = {r_rem, r_quo[31]};
    assign div_sub = div_try - {1'b0, r_den};
    assign dec_val = r_neg ? 32'(-r_quo) : r_quo;

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_R_WS: begin
                m_a = {2'b00, r_weight};
                m_b = {1'b0, r_slow_weight};
            end
            S_R_WF: begin
                m_a = {2'b00, r_weight};
                m_b = {1'b0, r_fast_weight};
            end
            S_R_LS: begin
                m_a = {r_lag[31], r_lag};
                m_b = {15'd0, r_ws};
            end
            S_R_LF: begin
                m_a = {r_lag[31], r_lag};
                m_b = {15'd0, r_wf};
            end
            S_T_RISE: begin
                m_a = {2'b00, r_max_speedup};
                m_b = {16'd0, r_dt};
            end
            S_T_DMUL: begin
                m_a = r_sel ? {r_fast[31], r_fast} : {r_slow[31], r_slow};
                m_b = r_sel ? {1'b0, r_fast_T} : {1'b0, r_slow_T};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = m_a * m_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_max_speedup <= drle_pkg::RST_MAX_SPEEDUP;
            r_slow_T      <= drle_pkg::RST_SLOW_DECAY_TIME;
            r_fast_T      <= drle_pkg::RST_FAST_DECAY_TIME;
            r_slow_weight <= drle_pkg::RST_SLOW_WEIGHT;
            r_fast_weight <= drle_pkg::RST_FAST_WEIGHT;
            r_sel_limit   <= drle_pkg::RST_SINGLE_EVENT_LIMIT;
            r_lst         <= '0;
            r_slow        <= '0;
            r_fast        <= '0;
            r_smooth      <= '0;
            r_out_valid   <= 1'b0;
            r_sel         <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (drle_pkg::t_cfg_idx'(i_cfg_idx))
                    drle_pkg::CFG_MAX_SPEEDUP:        r_max_speedup <= i_cfg_data;
                    drle_pkg::CFG_SLOW_DECAY_TIME:    r_slow_T      <= i_cfg_data;
                    drle_pkg::CFG_FAST_DECAY_TIME:    r_fast_T      <= i_cfg_data;
                    drle_pkg::CFG_SLOW_WEIGHT:        r_slow_weight <= i_cfg_data;
                    drle_pkg::CFG_FAST_WEIGHT:        r_fast_weight <= i_cfg_data;
                    drle_pkg::CFG_SINGLE_EVENT_LIMIT: r_sel_limit   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            r_prod <= m_p[63:0];

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_lag    <= lag_clamped;
                        r_weight <= i_in_req.report_weight;
                        r_dt     <= dt_clamped;
                        r_dec_s  <= quiet_pos && (quiet[47:0] > {17'd0, r_slow_T});
                        r_dec_f  <= quiet_pos && (quiet[47:0] > {17'd0, r_fast_T});
                        if (i_in_req.opcode == drle_pkg::OP_REPORT) begin
                            if (i_in_req.report_weight > drle_pkg::ONE_Q16) begin
                                r_lst <= i_in_req.now_time;
                            end
                            r_state <= S_R_WS;
                        end else begin
                            r_state <= S_T_RISE;
                        end
                    end
                end
                S_R_WS: begin
                    r_state <= S_R_WF;
                end
                S_R_WF: begin
                    r_ws    <= clamp_weight(r_prod);
                    r_state <= S_R_LS;
                end
                S_R_LS: begin
                    r_wf    <= clamp_weight(r_prod);
                    r_state <= S_R_LF;
                end
                S_R_LF: begin
                    r_slow  <= sat32({{17{slow_base[31]}}, slow_base}
                                     + {lag_term[47], lag_term});
                    r_state <= S_R_FIN;
                end
                S_R_FIN: begin
                    r_fast  <= sat32({{17{r_smooth[31]}}, r_smooth}
                                     + {lag_term[47], lag_term});
                    r_state <= S_DONE;
                end
                S_T_RISE: begin
                    r_state <= S_T_LIM;
                end
                S_T_LIM: begin
                    r_fast   <= fast_max;
                    r_smooth <= (smooth_rise > fast_max) ? fast_max : smooth_rise;
                    if (r_dec_s) begin
                        r_sel   <= 1'b0;
                        r_state <= S_T_DMUL;
                    end else if (r_dec_f) begin
                        r_sel   <= 1'b1;
                        r_state <= S_T_DMUL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_T_DMUL: begin
                    r_state <= S_T_DSET;
                end
                S_T_DSET: begin
                    if (dec_den == 32'd0) begin
                        if (!r_sel && r_dec_f) begin
                            r_sel   <= 1'b1;
                            r_state <= S_T_DMUL;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_den   <= dec_den;
                        r_neg   <= r_prod[63];
                        r_rem   <= dec_mag[63:32];
                        r_quo   <= dec_mag[31:0];
                        r_cnt   <= '0;
                        r_state <= S_T_DIV;
                    end
                end
                S_T_DIV: begin
                    if (!div_sub[32]) begin
                        r_rem <= div_sub[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= div_try[31:0];
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_T_DEND;
                    end
                end
                S_T_DEND: begin
                    if (r_sel) begin
                        r_fast <= dec_val;
                    end else begin
                        r_slow <= dec_val;
                    end
                    if (!r_sel && r_dec_f) begin
                        r_sel   <= 1'b1;
                        r_state <= S_T_DMUL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.smooth_lag <= r_smooth;
                        r_out.fast_lag   <= r_fast;
                        r_out.slow_lag   <= r_slow;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/drle_checker.sv]
module drle_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input drle_pkg::t_out_req o_out_req
);

    // The block works on a request through several states, so it must stall its input at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a request was accepted");

    // A new result only appears at the end of a request that was being worked on.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

    // The result cannot appear in the cycle straight after acceptance.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_req)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear the handshake state");

endmodule

bind dual_rate_lag_estimator drle_checker u_drle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);
